// ===== design/sparse_polynomial_adder_defines.svh =====
// Assertion macros used by the checker file of the polynomial adder.
`ifndef SPARSE_POLYNOMIAL_ADDER_DEFINES_SVH
`define SPARSE_POLYNOMIAL_ADDER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPA_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("polynomial adder port check failed");

// The consequent must hold in the cycle after the antecedent.
`define SPA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("polynomial adder port check failed");

`endif

// ===== design/spa_pkg.sv =====
package spa_pkg;

  localparam int COEF_W = 32;
  localparam int EXP_W = 16;
  localparam int OP_W = 2;
  localparam int ST_W = 2;

  // An add word never emits more result words than this.
  localparam int MAX_RESULTS = 32;
  localparam int RES_CNT_W = $clog2(MAX_RESULTS);

  localparam logic [OP_W-1:0] OP_INS_FIRST = 2'd0;
  localparam logic [OP_W-1:0] OP_INS_SECOND = 2'd1;
  localparam logic [OP_W-1:0] OP_ADD = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd3;

  localparam logic [ST_W-1:0] ST_OK = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL = 2'd1;
  localparam logic [ST_W-1:0] ST_SAT = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]          operation;
    logic signed [COEF_W-1:0] coefficient;
    logic signed [EXP_W-1:0]  exponent;
  } cmd_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] sum_coefficient;
    logic signed [EXP_W-1:0]  sum_exponent;
    logic                     term_valid;
    logic [ST_W-1:0]          status;
    logic                     last;
  } result_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] coef;
    logic signed [EXP_W-1:0]  expo;
  } term_t;

  typedef struct packed {
    logic gt;
    logic eq;
    logic sat;
  } cmp_t;

endpackage

// ===== design/spa_table.sv =====
module spa_table #(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  spa_pkg::term_t           wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output spa_pkg::term_t           rdata
);
  import spa_pkg::*;

  term_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/spa_addcmp.sv =====
module spa_addcmp (
  input  spa_pkg::term_t                   a,
  input  spa_pkg::term_t                   b,
  output logic signed [spa_pkg::COEF_W-1:0] sum,
  output spa_pkg::cmp_t                    flags
);
  import spa_pkg::*;

  logic [COEF_W:0] wide;

  assign wide = {a.coef[COEF_W-1], a.coef} + {b.coef[COEF_W-1], b.coef};

  always_comb begin
    flags.gt = a.expo > b.expo;
    flags.eq = a.expo == b.expo;
    // The two top bits of the widened sum differ exactly on overflow.
    flags.sat = wide[COEF_W] != wide[COEF_W-1];
    if (flags.sat) begin
      sum = wide[COEF_W] ? {1'b1, {(COEF_W-1){1'b0}}} : {1'b0, {(COEF_W-1){1'b1}}};
    end else begin
      sum = wide[COEF_W-1:0];
    end
  end

endmodule

// ===== design/sparse_polynomial_adder.sv =====
// Channel   Ports                 Handshake
// command   cmd                   taken when start is high and busy is low
// result    result                shown for one cycle while done is high
//
// Insert: busy while it searches the table entry by entry, shifts each entry
// below the new place down and writes the new term; the result word follows.
// Add: the sum terms come back to back after acceptance (up to 32), since the
// single read port of each table yields one entry a cycle. Clear: a status word.
// Reset returns to idle, drops done and empties the two term counts; the tables need no clearing pass.
// Result words cannot be stalled; busy stays high until the last word shows.
module sparse_polynomial_adder #(
  parameter int MAX_TERMS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  spa_pkg::cmd_t    cmd,
  output logic             done,
  output spa_pkg::result_t result
);
  import spa_pkg::*;

  localparam int IW = $clog2(MAX_TERMS);
  localparam int CW = $clog2(MAX_TERMS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SRCH,
    S_SHIFT,
    S_INS_WR,
    S_EMPTY,
    S_MERGE
  } state_t;

  state_t                 state, state_next;
  cmd_t                   item, item_next;
  logic                   sel, sel_next;
  logic [CW-1:0]          pos, pos_next;
  logic [CW-1:0]          shift_i, shift_i_next;
  logic [CW-1:0]          mi, mi_next;
  logic [CW-1:0]          mj, mj_next;
  logic [RES_CNT_W-1:0]   k, k_next;
  logic [CW-1:0]          first_count, first_count_next;
  logic [CW-1:0]          second_count, second_count_next;
  result_t                result_next;
  logic                   done_next;

  logic                   we;
  logic [IW-1:0]          waddr;
  term_t                  wdata;
  logic [IW-1:0]          raddr1, raddr2;
  term_t                  rd1, rd2, rd_sel, item_term;
  term_t                  op_a, op_b;
  logic signed [COEF_W-1:0] sum;
  cmp_t                   flags;

  logic [CW-1:0]          n_sel, pos_inc, n_dec, sh_dec, sh_dec2;
  logic                   v1, v2, take1, take2;
  logic [CW-1:0]          mi_adv, mj_adv;

  function automatic result_t status_word(logic [ST_W-1:0] st);
    result_t w;
    w = '0;
    w.status = st;
    w.last = 1'b1;
    return w;
  endfunction

  spa_table #(.DEPTH(MAX_TERMS)) u_first (
    .clk   (clk),
    .we    (we && !sel),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr1),
    .rdata (rd1)
  );

  spa_table #(.DEPTH(MAX_TERMS)) u_second (
    .clk   (clk),
    .we    (we && sel),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr2),
    .rdata (rd2)
  );

  spa_addcmp u_unit (
    .a     (op_a),
    .b     (op_b),
    .sum   (sum),
    .flags (flags)
  );

  assign busy = state != S_IDLE;
  assign rd_sel = sel ? rd2 : rd1;
  assign item_term = '{coef: item.coefficient, expo: item.exponent};
  assign op_a = (state == S_MERGE) ? rd1 : rd_sel;
  assign op_b = (state == S_MERGE) ? rd2 : item_term;

  assign n_sel = sel ? second_count : first_count;
  assign pos_inc = pos + 1'b1;
  assign n_dec = n_sel - 1'b1;
  assign sh_dec = shift_i - 1'b1;
  assign sh_dec2 = shift_i - CW'(2);

  // Merge selection follows the descending exponent order of both tables.
  assign v1 = mi < first_count;
  assign v2 = mj < second_count;
  assign take1 = !v2 || (v1 && flags.gt);
  assign take2 = !take1 && (!v1 || !flags.eq);
  assign mi_adv = take2 ? mi : mi + 1'b1;
  assign mj_adv = take1 ? mj : mj + 1'b1;

  always_comb begin
    state_next = state;
    item_next = item;
    sel_next = sel;
    pos_next = pos;
    shift_i_next = shift_i;
    mi_next = mi;
    mj_next = mj;
    k_next = k;
    first_count_next = first_count;
    second_count_next = second_count;
    result_next = result;
    done_next = 1'b0;
    we = 1'b0;
    waddr = pos[IW-1:0];
    wdata = item_term;
    raddr1 = '0;
    raddr2 = '0;

    case (state)
      S_IDLE: begin
        if (start) begin
          item_next = cmd;
          case (cmd.operation)
            OP_INS_FIRST, OP_INS_SECOND: begin
              sel_next = cmd.operation[0];
              pos_next = '0;
              if ((cmd.operation[0] ? second_count : first_count) == '0) begin
                state_next = S_INS_WR;
              end else begin
                state_next = S_SRCH;
              end
            end
            OP_ADD: begin
              mi_next = '0;
              mj_next = '0;
              k_next = '0;
              if (first_count == '0 && second_count == '0) begin
                state_next = S_EMPTY;
              end else begin
                state_next = S_MERGE;
              end
            end
            OP_CLEAR: begin
              first_count_next = '0;
              second_count_next = '0;
              state_next = S_EMPTY;
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end

      S_SRCH: begin
        if (flags.eq) begin
          we = 1'b1;
          wdata.coef = sum;
          result_next = status_word(flags.sat ? ST_SAT : ST_OK);
          done_next = 1'b1;
          state_next = S_IDLE;
        end else if (flags.gt && pos_inc != n_sel) begin
          pos_next = pos_inc;
          raddr1 = pos_inc[IW-1:0];
          raddr2 = pos_inc[IW-1:0];
        end else if (n_sel == CW'(MAX_TERMS)) begin
          result_next = status_word(ST_FULL);
          done_next = 1'b1;
          state_next = S_IDLE;
        end else if (flags.gt) begin
          // New smallest exponent goes straight to the end of the table.
          pos_next = pos_inc;
          state_next = S_INS_WR;
        end else begin
          shift_i_next = n_sel;
          raddr1 = n_dec[IW-1:0];
          raddr2 = n_dec[IW-1:0];
          state_next = S_SHIFT;
        end
      end

      S_SHIFT: begin
        we = 1'b1;
        waddr = shift_i[IW-1:0];
        wdata = rd_sel;
        if (sh_dec == pos) begin
          state_next = S_INS_WR;
        end else begin
          shift_i_next = sh_dec;
          raddr1 = sh_dec2[IW-1:0];
          raddr2 = sh_dec2[IW-1:0];
        end
      end

      S_INS_WR: begin
        we = 1'b1;
        if (sel) begin
          second_count_next = second_count + 1'b1;
        end else begin
          first_count_next = first_count + 1'b1;
        end
        result_next = status_word(ST_OK);
        done_next = 1'b1;
        state_next = S_IDLE;
      end

      S_EMPTY: begin
        result_next = status_word(ST_OK);
        done_next = 1'b1;
        state_next = S_IDLE;
      end

      S_MERGE: begin
        result_next.term_valid = 1'b1;
        result_next.status = ST_OK;
        if (take1) begin
          result_next.sum_coefficient = rd1.coef;
          result_next.sum_exponent = rd1.expo;
        end else if (take2) begin
          result_next.sum_coefficient = rd2.coef;
          result_next.sum_exponent = rd2.expo;
        end else begin
          result_next.sum_coefficient = sum;
          result_next.sum_exponent = rd1.expo;
          result_next.status = flags.sat ? ST_SAT : ST_OK;
        end
        result_next.last = (mi_adv >= first_count && mj_adv >= second_count) ||
                           (k == RES_CNT_W'(MAX_RESULTS - 1));
        done_next = 1'b1;
        mi_next = mi_adv;
        mj_next = mj_adv;
        k_next = k + 1'b1;
        raddr1 = mi_adv[IW-1:0];
        raddr2 = mj_adv[IW-1:0];
        if (result_next.last) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    // Reads for the first search or merge step are issued on acceptance.
    if (state == S_IDLE) begin
      raddr1 = '0;
      raddr2 = '0;
    end
  end

  always_ff @(posedge clk) begin
    item <= item_next;
    sel <= sel_next;
    pos <= pos_next;
    shift_i <= shift_i_next;
    mi <= mi_next;
    mj <= mj_next;
    k <= k_next;
    result <= result_next;
    if (rst) begin
      state <= S_IDLE;
      first_count <= '0;
      second_count <= '0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      first_count <= first_count_next;
      second_count <= second_count_next;
      done <= done_next;
    end
  end

endmodule

// ===== design/spa_checker.sv =====
`include "sparse_polynomial_adder_defines.svh"

module spa_checker (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input spa_pkg::result_t result
);
  import spa_pkg::*;

  // A word without a term always closes its command.
  `SPA_ASSERT_SAME(a_empty_word_last, clk, rst, done && !result.term_valid, result.last)
  // A sum word that is not the last is followed at once by another word.
  `SPA_ASSERT_NEXT(a_sum_words_contiguous, clk, rst, done && !result.last, done)
  // Every accepted command raises busy in the cycle after it is taken.
  `SPA_ASSERT_NEXT(a_accept_sets_busy, clk, rst, start && !busy, busy)
  // Sum terms never report a dropped insert.
  `SPA_ASSERT_SAME(a_sum_status, clk, rst, done && result.term_valid, result.status != ST_FULL)

endmodule

bind sparse_polynomial_adder spa_checker u_spa_checker (.*);

// ===== tb/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import spa_pkg::*;

  localparam int TERMS = 16;
  localparam int RANDOM_WORDS = 330;
  localparam int RUN_LIMIT = 200000;
  // Longest insert walks and shifts the whole table.
  localparam int DRAIN_CYCLES = 2 * TERMS + 8;

  localparam logic signed [COEF_W-1:0] COEF_MAX = 32'sh7fffffff;
  localparam logic signed [COEF_W-1:0] COEF_MIN = 32'sh80000000;
  localparam logic signed [EXP_W-1:0] EXP_MAX = 16'sh7fff;
  localparam logic signed [EXP_W-1:0] EXP_MIN = 16'sh8000;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic done;
  cmd_t cmd;
  result_t result;

  // Shadow copies of the two polynomials, index 0 is first and 1 is second.
  logic signed [COEF_W-1:0] poly_coef [2][TERMS];
  logic signed [EXP_W-1:0] poly_exp [2][TERMS];
  int poly_len [2];
  result_t pending_results [$];

  int failures;
  int words_sent;
  int sums_sent;
  int results_seen;
  int sat_seen;
  int full_seen;
  int cycle_count;
  int burst_left;

  sparse_polynomial_adder #(.MAX_TERMS(TERMS)) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .done(done),
    .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic signed [COEF_W-1:0] clamp_add(
    input logic signed [COEF_W-1:0] a,
    input logic signed [COEF_W-1:0] b,
    output logic sat
  );
    logic signed [COEF_W:0] s;
    s = a + b;
    sat = s[COEF_W] ^ s[COEF_W-1];
    if (!sat) return s[COEF_W-1:0];
    return s[COEF_W] ? COEF_MIN : COEF_MAX;
  endfunction

  function automatic logic [ST_W-1:0] place_term(
    input int t,
    input logic signed [COEF_W-1:0] c,
    input logic signed [EXP_W-1:0] e
  );
    int pos;
    logic sat;
    pos = 0;
    while (pos < poly_len[t] && poly_exp[t][pos] > e) pos++;
    if (pos < poly_len[t] && poly_exp[t][pos] == e) begin
      poly_coef[t][pos] = clamp_add(poly_coef[t][pos], c, sat);
      return sat ? ST_SAT : ST_OK;
    end
    if (poly_len[t] >= TERMS) return ST_FULL;
    for (int i = poly_len[t]; i > pos; i--) begin
      poly_coef[t][i] = poly_coef[t][i-1];
      poly_exp[t][i] = poly_exp[t][i-1];
    end
    poly_coef[t][pos] = c;
    poly_exp[t][pos] = e;
    poly_len[t]++;
    return ST_OK;
  endfunction

  function automatic void predict_word(input cmd_t w);
    result_t r;
    int i;
    int j;
    int k;
    logic sat;
    r = '0;
    r.last = 1'b1;
    case (w.operation)
      OP_INS_FIRST: begin
        r.status = place_term(0, w.coefficient, w.exponent);
        pending_results.push_back(r);
      end
      OP_INS_SECOND: begin
        r.status = place_term(1, w.coefficient, w.exponent);
        pending_results.push_back(r);
      end
      OP_CLEAR: begin
        poly_len[0] = 0;
        poly_len[1] = 0;
        pending_results.push_back(r);
      end
      default: begin
        if (poly_len[0] == 0 && poly_len[1] == 0) begin
          pending_results.push_back(r);
        end else begin
          i = 0;
          j = 0;
          k = 0;
          // Walk both sorted tables from the highest exponent down.
          while ((i < poly_len[0] || j < poly_len[1]) && k < MAX_RESULTS) begin
            sat = 1'b0;
            if (j >= poly_len[1] || (i < poly_len[0] && poly_exp[0][i] > poly_exp[1][j])) begin
              r.sum_coefficient = poly_coef[0][i];
              r.sum_exponent = poly_exp[0][i];
              i++;
            end else if (i >= poly_len[0] || poly_exp[0][i] < poly_exp[1][j]) begin
              r.sum_coefficient = poly_coef[1][j];
              r.sum_exponent = poly_exp[1][j];
              j++;
            end else begin
              r.sum_coefficient = clamp_add(poly_coef[0][i], poly_coef[1][j], sat);
              r.sum_exponent = poly_exp[0][i];
              i++;
              j++;
            end
            r.term_valid = 1'b1;
            r.status = sat ? ST_SAT : ST_OK;
            r.last = (i >= poly_len[0] && j >= poly_len[1]) || (k + 1 >= MAX_RESULTS);
            pending_results.push_back(r);
            k++;
          end
        end
      end
    endcase
  endfunction

  function automatic void check_result(input result_t got);
    result_t want;
    results_seen++;
    if (pending_results.size() == 0) begin
      $error("result word with nothing expected: %p", got);
      failures++;
      return;
    end
    want = pending_results.pop_front();
    if (want.status == ST_SAT) sat_seen++;
    if (want.status == ST_FULL) full_seen++;
    if (got.sum_coefficient !== want.sum_coefficient) begin
      $error("sum_coefficient: expected %0d, actual %0d", want.sum_coefficient,
             got.sum_coefficient);
      failures++;
    end
    if (got.sum_exponent !== want.sum_exponent) begin
      $error("sum_exponent: expected %0d, actual %0d", want.sum_exponent, got.sum_exponent);
      failures++;
    end
    if (got.term_valid !== want.term_valid) begin
      $error("term_valid: expected %0b, actual %0b", want.term_valid, got.term_valid);
      failures++;
    end
    if (got.status !== want.status) begin
      $error("status: expected %0d, actual %0d", want.status, got.status);
      failures++;
    end
    if (got.last !== want.last) begin
      $error("last: expected %0b, actual %0b", want.last, got.last);
      failures++;
    end
  endfunction

  // Results are checked before a word taken at the same edge is predicted,
  // since that word's results can only show later.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end else if (!rst) begin
      if (done) check_result(result);
      if (start && !busy) predict_word(cmd);
    end
  end

  // Sends one command word; the sender keeps start high through a burst and
  // idles for a random gap between bursts.
  task automatic send_word(
    input logic [OP_W-1:0] op,
    input logic signed [COEF_W-1:0] c,
    input logic signed [EXP_W-1:0] e
  );
    cmd_t w;
    w.operation = op;
    w.coefficient = c;
    w.exponent = e;
    @(negedge clk);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
    end
    start <= 1'b1;
    cmd <= w;
    burst_left--;
    do @(posedge clk); while (busy);
    words_sent++;
    if (op == OP_ADD) sums_sent++;
  endtask

  function automatic logic signed [COEF_W-1:0] rand_coef();
    case ($urandom_range(0, 5))
      0: return COEF_MAX;
      1: return COEF_MIN;
      2: return $urandom_range(0, 20) - 10;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [EXP_W-1:0] rand_exp(input bit narrow);
    case ($urandom_range(0, 9))
      0: return EXP_MAX;
      1: return EXP_MIN;
      default: begin
        if (narrow) return EXP_W'($urandom_range(0, 23) - 12);
        return EXP_W'($urandom);
      end
    endcase
  endfunction

  task automatic test_empty_and_clear();
    send_word(OP_CLEAR, 0, 0);
    send_word(OP_ADD, 0, 0);
    // Clear ignores the term fields, so give it junk in them.
    send_word(OP_CLEAR, COEF_MIN, EXP_MAX);
    send_word(OP_ADD, COEF_MAX, EXP_MIN);
  endtask

  task automatic test_saturation();
    send_word(OP_INS_FIRST, COEF_MAX, EXP_MAX);
    send_word(OP_INS_FIRST, 1, EXP_MAX);
    send_word(OP_INS_FIRST, COEF_MIN, EXP_MIN);
    send_word(OP_INS_FIRST, -1, EXP_MIN);
    send_word(OP_INS_FIRST, 0, 0);
    send_word(OP_INS_SECOND, 1, EXP_MAX);
    send_word(OP_INS_SECOND, COEF_MIN, EXP_MIN);
    send_word(OP_INS_SECOND, 5, -3);
    send_word(OP_ADD, 0, 0);
  endtask

  task automatic test_table_full();
    send_word(OP_CLEAR, 0, 0);
    // Scrambled exponents so that inserts land all over the table.
    for (int i = 0; i < TERMS; i++) begin
      send_word(OP_INS_SECOND, i + 1, EXP_W'(((i * 7) % TERMS) * 4 - 30));
    end
    send_word(OP_INS_SECOND, 99, 1);
    send_word(OP_INS_SECOND, 3, -30);
    send_word(OP_ADD, 0, 0);
  endtask

  task automatic test_random_polynomials();
    int base;
    bit narrow;
    base = words_sent;
    while (words_sent - base < RANDOM_WORDS) begin
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          send_word(OP_W'($urandom_range(0, 3)), $urandom, EXP_W'($urandom));
        end
      end else begin
        if ($urandom_range(0, 2) != 0) send_word(OP_CLEAR, $urandom, EXP_W'($urandom));
        narrow = ($urandom_range(0, 1) == 1);
        repeat ($urandom_range(0, 20)) begin
          send_word($urandom_range(0, 1) ? OP_INS_SECOND : OP_INS_FIRST, rand_coef(),
                    rand_exp(narrow));
        end
        send_word(OP_ADD, $urandom, EXP_W'($urandom));
        if ($urandom_range(0, 3) == 0) send_word(OP_ADD, $urandom, EXP_W'($urandom));
      end
    end
  endtask

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    cmd <= '0;
    poly_len[0] = 0;
    poly_len[1] = 0;
    failures = 0;
    words_sent = 0;
    sums_sent = 0;
    results_seen = 0;
    sat_seen = 0;
    full_seen = 0;
    cycle_count = 0;
    burst_left = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_and_clear();
    test_saturation();
    test_table_full();
    test_random_polynomials();

    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d command words, %0d of them sums, and checked %0d result words.",
             words_sent, sums_sent, results_seen);
    $display("Outcomes included %0d saturated terms and %0d dropped inserts on a full table.",
             sat_seen, full_seen);
    if (failures == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
